### hw/rtl/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and constants of the page slot allocator: field widths,
// operation and status codes, and the control state type.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int OP_W          = 2;
  localparam int PAGE_FIELD_W  = 10;
  localparam int SLOT_FIELD_W  = 6;
  localparam int STATUS_W      = 3;
  localparam int TOTAL_FIELD_W = 17;
  localparam int PAGES_FIELD_W = 11;
  localparam int CFG_W         = 7;

  localparam logic [CFG_W-1:0] CFG_SPP_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_PAGE_RANGE = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_SLOT_RANGE = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

### hw/rtl/psa_page_ram.sv
// ----------------------------------------------------------------------------
// psa_page_ram
// Page descriptor memory: one write port, one read port, registered read
// data. Read data holds until the next read.
// ----------------------------------------------------------------------------
module psa_page_ram #(
  parameter int AW = 10,
  parameter int DW = 83
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/psa_free_slot.sv
// ----------------------------------------------------------------------------
// psa_free_slot
// Lowest free slot search: finds the lowest clear bitmap bit below the
// usable slot count of the page.
// ----------------------------------------------------------------------------
module psa_free_slot #(
  parameter int SLOTS = 64,
  parameter int CW    = 7,
  parameter int SIW   = 6
) (
  input  logic [SLOTS-1:0] bitmap,
  input  logic [CW-1:0]    spp,
  output logic             found,
  output logic [SIW-1:0]   slot
);

  logic [SLOTS-1:0] free_v;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_v[i] = !bitmap[i] && (i < int'(spp));
    end
  end

  // Scan from the top so the lowest free slot wins.
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_v[i]) begin
        found = 1'b1;
        slot  = SIW'(i);
      end
    end
  end

endmodule

### hw/rtl/page_slot_allocator.sv
// ----------------------------------------------------------------------------
// page_slot_allocator
// Two-level record slot allocator: per-page slot bitmaps, record counts and
// a linked list of pages with free slots, kept in one page memory.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in_     | in        | in_valid/in_stall  | operation, page_index, slot_index
//  out_    | out       | out_valid/out_stall| status, result_page, result_slot,
//          |           |                    | total_records, pages_in_use
//  cfg_    | in        | cfg_valid/cfg_ready| slots_per_page
//
//  On accept the page descriptor is read; in the execute step it is
//  modified and written back, and the result register is loaded.
//  The page memory takes a single read-modify-write per item.
//  Reset clears the list head, page and record totals; page memory is not
//  cleared, since a page is initialized when it is opened.
//  A stalled result holds the block in the execute step; a new item is taken
//  once the execute step has retired.
// ----------------------------------------------------------------------------
module page_slot_allocator #(
  parameter int MAX_PAGES = 1024,
  parameter int SLOTS     = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [psa_pkg::CFG_W-1:0]            cfg_slots_per_page,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [psa_pkg::OP_W-1:0]             in_operation,
  input  logic [psa_pkg::PAGE_FIELD_W-1:0]     in_page_index,
  input  logic [psa_pkg::SLOT_FIELD_W-1:0]     in_slot_index,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [psa_pkg::STATUS_W-1:0]         out_status,
  output logic [psa_pkg::PAGE_FIELD_W-1:0]     out_result_page,
  output logic [psa_pkg::SLOT_FIELD_W-1:0]     out_result_slot,
  output logic [psa_pkg::TOTAL_FIELD_W-1:0]    out_total_records,
  output logic [psa_pkg::PAGES_FIELD_W-1:0]    out_pages_in_use
);

  // Widths derived from the table geometry.
  localparam int AW  = $clog2(MAX_PAGES);             // page memory address
  localparam int PW  = $clog2(MAX_PAGES + 1);         // head / page total
  localparam int CW  = $clog2(SLOTS + 1);             // per-page record count
  localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW  = $clog2(MAX_PAGES * SLOTS + 1); // record total

  // Page descriptor layout: {in_list, next, count, bitmap}.
  localparam int BMP_LO  = 0;
  localparam int CNT_LO  = SLOTS;
  localparam int NEXT_LO = SLOTS + CW;
  localparam int LIST_B  = SLOTS + CW + PW;
  localparam int DW      = SLOTS + CW + PW + 1;

  localparam logic [PW-1:0] HEAD_NONE = PW'(MAX_PAGES);

  // --------------------------------------------------------------------------
  // Control and architectural state
  // --------------------------------------------------------------------------
  psa_pkg::state_t state_r, state_nxt;

  logic [psa_pkg::CFG_W-1:0]        cfg_spp_r;
  logic [PW-1:0]                    head_r, head_nxt;
  logic [PW-1:0]                    pages_r, pages_nxt;
  logic [TW-1:0]                    recs_r, recs_nxt;

  // Latched item fields
  logic [psa_pkg::OP_W-1:0]         op_r;
  logic [psa_pkg::PAGE_FIELD_W-1:0] pg_r;
  logic [psa_pkg::SLOT_FIELD_W-1:0] sl_r;

  // Result register
  logic                             out_valid_r;
  logic [psa_pkg::STATUS_W-1:0]     out_status_r, status_nxt;
  logic [psa_pkg::PAGE_FIELD_W-1:0] out_page_r, page_nxt;
  logic [psa_pkg::SLOT_FIELD_W-1:0] out_slot_r, slot_nxt;
  logic [psa_pkg::TOTAL_FIELD_W-1:0] out_total_r;
  logic [psa_pkg::PAGES_FIELD_W-1:0] out_pages_r;

  // Handshake / sequencing
  logic accept;
  logic advance;
  logic out_free;

  // Memory ports
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  // Effective slots per page: zero reads as one, clamp at SLOTS.
  logic [CW-1:0] spp;

  always_comb begin
    if (cfg_spp_r == '0) begin
      spp = CW'(1);
    end else if (int'(cfg_spp_r) > SLOTS) begin
      spp = CW'(SLOTS);
    end else begin
      spp = CW'(cfg_spp_r);
    end
  end

  // Fields of the page descriptor just read.
  logic             e_list;
  logic [PW-1:0]    e_next;
  logic [CW-1:0]    e_cnt;
  logic [SLOTS-1:0] e_bmp;

  assign e_list = rd_data[LIST_B];
  assign e_next = rd_data[NEXT_LO +: PW];
  assign e_cnt  = rd_data[CNT_LO +: CW];
  assign e_bmp  = rd_data[BMP_LO +: SLOTS];

  logic           ff_found;
  logic [SIW-1:0] ff_slot;

  psa_free_slot #(
    .SLOTS (SLOTS),
    .CW    (CW),
    .SIW   (SIW)
  ) u_free_slot (
    .bitmap (e_bmp),
    .spp    (spp),
    .found  (ff_found),
    .slot   (ff_slot)
  );

  psa_page_ram #(
    .AW (AW),
    .DW (DW)
  ) u_page_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  // Result register is free when empty or drained this cycle.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = psa_pkg::ST_EXEC;
        end
      end
      psa_pkg::ST_EXEC: begin
        if (out_free) begin
          state_nxt = psa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = psa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    advance   = 1'b0;
    case (state_r)
      psa_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
      end
      psa_pkg::ST_EXEC: begin
        advance = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign accept = in_valid && !in_stall;

  // Read the head page for inserts, the addressed page otherwise.
  assign rd_en   = accept;
  assign rd_addr = (in_operation == psa_pkg::OP_INSERT) ? AW'(head_r) : AW'(in_page_index);

  // --------------------------------------------------------------------------
  // Execute: modify the descriptor, update totals and list head
  // --------------------------------------------------------------------------
  logic             wr_req;
  logic [CW:0]      cnt_inc;
  logic [SLOTS-1:0] bmp_set;
  logic [SLOTS-1:0] bmp_clr;
  logic [SIW-1:0]   sl_idx;

  assign cnt_inc = {1'b0, e_cnt} + (CW+1)'(1);
  assign bmp_set = e_bmp | (SLOTS'(1) << ff_slot);
  assign sl_idx  = SIW'(sl_r);
  assign bmp_clr = e_bmp & ~(SLOTS'(1) << sl_idx);

  always_comb begin
    head_nxt   = head_r;
    pages_nxt  = pages_r;
    recs_nxt   = recs_r;
    wr_req     = 1'b0;
    wr_addr    = AW'(pg_r);
    wr_data    = rd_data;
    status_nxt = psa_pkg::STATUS_OK;
    page_nxt   = pg_r;
    slot_nxt   = sl_r;

    if (op_r == psa_pkg::OP_INSERT) begin
      if (head_r == HEAD_NONE) begin
        page_nxt = '0;
        slot_nxt = '0;
        if (pages_r == PW'(MAX_PAGES)) begin
          // Every page opened and none has room.
          status_nxt = psa_pkg::STATUS_FULL;
        end else begin
          // Open a fresh page and take its slot zero; a one-slot page is
          // full at once and stays off the list.
          wr_req    = 1'b1;
          wr_addr   = AW'(pages_r);
          wr_data   = '0;
          wr_data[LIST_B]          = (spp > CW'(1));
          wr_data[NEXT_LO +: PW]   = HEAD_NONE;
          wr_data[CNT_LO +: CW]    = CW'(1);
          wr_data[BMP_LO +: SLOTS] = SLOTS'(1);
          if (spp > CW'(1)) begin
            head_nxt = pages_r;
          end
          pages_nxt = pages_r + PW'(1);
          recs_nxt  = recs_r + TW'(1);
          page_nxt  = psa_pkg::PAGE_FIELD_W'(pages_r);
        end
      end else begin
        wr_req   = 1'b1;
        wr_addr  = AW'(head_r);
        page_nxt = psa_pkg::PAGE_FIELD_W'(head_r);
        slot_nxt = '0;
        if (!ff_found) begin
          // Head page has no slot below the current limit: unlink it.
          head_nxt        = e_next;
          wr_data[LIST_B] = 1'b0;
          status_nxt      = psa_pkg::STATUS_FULL;
        end else begin
          wr_data[BMP_LO +: SLOTS] = bmp_set;
          wr_data[CNT_LO +: CW]    = CW'(cnt_inc);
          recs_nxt = recs_r + TW'(1);
          slot_nxt = psa_pkg::SLOT_FIELD_W'(ff_slot);
          if (cnt_inc >= {1'b0, spp}) begin
            head_nxt        = e_next;
            wr_data[LIST_B] = 1'b0;
          end
        end
      end
    end else begin
      if (int'(pg_r) >= int'(pages_r)) begin
        status_nxt = psa_pkg::STATUS_PAGE_RANGE;
      end else if (int'(sl_r) >= int'(spp)) begin
        status_nxt = psa_pkg::STATUS_SLOT_RANGE;
      end else if (!e_bmp[sl_idx]) begin
        status_nxt = psa_pkg::STATUS_EMPTY;
      end else if (op_r == psa_pkg::OP_DELETE) begin
        // Free the slot; push the page back on the list if it was off.
        wr_req = 1'b1;
        wr_data[BMP_LO +: SLOTS] = bmp_clr;
        if (e_cnt != '0) begin
          wr_data[CNT_LO +: CW] = e_cnt - CW'(1);
        end
        if (!e_list) begin
          wr_data[LIST_B]        = 1'b1;
          wr_data[NEXT_LO +: PW] = head_r;
          head_nxt               = PW'(pg_r);
        end
        if (recs_r != '0) begin
          recs_nxt = recs_r - TW'(1);
        end
      end
    end
  end

  assign wr_en = advance && wr_req;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psa_pkg::ST_IDLE;
      cfg_spp_r   <= psa_pkg::CFG_SPP_RESET;
      head_r      <= HEAD_NONE;
      pages_r     <= '0;
      recs_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_spp_r <= cfg_slots_per_page;
      end
      if (advance) begin
        head_r      <= head_nxt;
        pages_r     <= pages_nxt;
        recs_r      <= recs_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the item fields for the execute step.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_operation;
      pg_r <= in_page_index;
      sl_r <= in_slot_index;
    end
  end

  // Load the result; it holds while stalled.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= status_nxt;
      out_page_r   <= page_nxt;
      out_slot_r   <= slot_nxt;
      out_total_r  <= psa_pkg::TOTAL_FIELD_W'(recs_nxt);
      out_pages_r  <= psa_pkg::PAGES_FIELD_W'(pages_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_page   = out_page_r;
  assign out_result_slot   = out_slot_r;
  assign out_total_records = out_total_r;
  assign out_pages_in_use  = out_pages_r;

endmodule
